// ===== hdl/mlr_pkg.sv =====
// Package for the loop recorder: beat types, mode and sequencer encodings,
// and store geometry. No dependencies; used by midi_loop_recorder.
package mlr_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int TIME_W      = 32;

    typedef enum logic [1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_NOTE    = 2'd2,
        FUNC_TICK    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WSTART = 3'd1,
        MODE_REC    = 3'd2,
        MODE_WEND   = 3'd3,
        MODE_PLAY   = 3'd4
    } t_mode;

    typedef enum logic [0:0] {
        ST_ACCEPT = 1'b0,
        ST_EMIT   = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0] func;
        logic       note_on;
        logic [6:0] note_number;
        logic [6:0] note_velocity;
        logic [4:0] midi_channel;
    } t_in_beat;

    typedef struct packed {
        logic       out_on;
        logic [6:0] out_note;
        logic [6:0] out_velocity;
        logic [4:0] out_channel;
    } t_out_beat;

    typedef struct packed {
        logic              on;
        logic [6:0]        note;
        logic [6:0]        vel;
        logic [4:0]        chan;
        logic [TIME_W-1:0] offs;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== hdl/mlr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/midi_loop_recorder.sv =====
// Top level of the MIDI loop recorder: mode control, millisecond timing and
// playback sequencing around the event store. Depends on mlr_pkg, mlr_ram.
//
//   Channel  Direction  Handshake               Beat type
//   in       input      i_in_valid / o_in_ready  mlr_pkg::t_in_beat
//   out      output     o_out_valid / i_out_ready mlr_pkg::t_out_beat
//
// Button beats and note beats are handled on acceptance. A playback tick reads
// the store entry at the play index (zero on a wrap) on acceptance; in ST_EMIT
// its offset is compared with the loop time and the entry is emitted if due.
// Reset clears the mode, counters and output valid; the store is not cleared,
// since only entries below the event count are ever used.
// A finished note waits in the output register; further beats are accepted
// meanwhile, and only a tick that has a note to play stalls while it is full.
module midi_loop_recorder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mlr_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mlr_pkg::t_out_beat o_out_beat
);

    import mlr_pkg::*;

    // Sequencer and recorder state.
    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic              r_have_take, n_have_take;
    logic [TIME_W-1:0] r_now_ms, n_now_ms;
    logic [TIME_W-1:0] r_record_start, n_record_start;
    logic [TIME_W-1:0] r_play_start, n_play_start;
    logic [TIME_W-1:0] r_loop_length, n_loop_length;
    logic [CNT_W-1:0]  r_event_count, n_event_count;
    logic [CNT_W-1:0]  r_play_index, n_play_index;
    logic [TIME_W-1:0] r_loop_time, n_loop_time;

    // Output register.
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out_beat, n_out_beat;

    // Store port signals.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_entry;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    t_entry            rd_entry;
    logic [ENTRY_W-1:0] rd_bits;

    logic              accept;
    logic              play_tick;
    logic [TIME_W-1:0] tick_now;
    logic [TIME_W-1:0] tick_elapsed;
    logic              tick_wrap;
    logic              store_full;
    logic              due;
    logic              slot_free;

    mlr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    assign rd_entry = t_entry'(rd_bits);

    assign accept     = i_in_valid && o_in_ready;
    assign store_full = (r_event_count == CNT_W'(STORE_DEPTH));

    // Tick timing: the counter advances first, then the loop time is taken
    // against the start of the current pass and wraps at the loop length.
    assign tick_now     = r_now_ms + TIME_W'(1);
    assign tick_elapsed = tick_now - r_play_start;
    assign tick_wrap    = (tick_elapsed >= r_loop_length);
    assign play_tick    = accept && (t_func'(i_in_beat.func) == FUNC_TICK)
                          && (r_mode == MODE_PLAY) && r_have_take;

    // In the emit cycle the read entry is due if it exists and its offset has
    // been reached.
    assign due       = (r_play_index < r_event_count) && (r_loop_time >= rd_entry.offs);
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACCEPT: begin
                if (play_tick) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!due || slot_free) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    // Sequencer outputs: input ready and the store read strobe.
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_play_index[IDX_W-1:0];
        unique case (r_state)
            ST_ACCEPT: begin
                o_in_ready = 1'b1;
                rd_en      = play_tick;
                if (tick_wrap) begin
                    rd_addr = '0;
                end
            end
            ST_EMIT: begin
                o_in_ready = 1'b0;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // Recorder datapath: mode changes, timing and store writes on accepted
    // beats, and the playback index and output load in the emit cycle.
    always_comb begin
        n_mode         = r_mode;
        n_have_take    = r_have_take;
        n_now_ms       = r_now_ms;
        n_record_start = r_record_start;
        n_play_start   = r_play_start;
        n_loop_length  = r_loop_length;
        n_event_count  = r_event_count;
        n_play_index   = r_play_index;
        n_loop_time    = r_loop_time;
        n_out_valid    = r_out_valid;
        n_out_beat     = r_out_beat;
        wr_en          = 1'b0;
        wr_addr        = r_event_count[IDX_W-1:0];
        wr_entry.on    = i_in_beat.note_on;
        wr_entry.note  = i_in_beat.note_number;
        wr_entry.vel   = i_in_beat.note_velocity;
        wr_entry.chan  = i_in_beat.midi_channel;
        wr_entry.offs  = r_now_ms - r_record_start;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            unique case (t_func'(i_in_beat.func))
                FUNC_PRESS: begin
                    if (r_mode == MODE_IDLE) begin
                        n_mode = MODE_WSTART;
                    end else if (r_mode == MODE_PLAY) begin
                        n_mode = MODE_IDLE;
                    end
                end
                FUNC_RELEASE: begin
                    if (r_mode == MODE_WSTART && r_have_take) begin
                        n_play_index = '0;
                        n_play_start = r_now_ms;
                        n_mode       = MODE_PLAY;
                    end else if (r_mode == MODE_REC) begin
                        n_mode = MODE_WEND;
                    end
                end
                FUNC_NOTE: begin
                    if (r_mode == MODE_WSTART && i_in_beat.note_on) begin
                        // First note-on opens a new take at offset zero.
                        n_have_take    = 1'b0;
                        n_mode         = MODE_REC;
                        n_record_start = r_now_ms;
                        wr_en          = 1'b1;
                        wr_addr        = '0;
                        wr_entry.offs  = '0;
                        n_event_count  = CNT_W'(1);
                    end else if (r_mode == MODE_WEND && i_in_beat.note_on) begin
                        // Closing note-on: not stored, sets the loop length.
                        n_loop_length = r_now_ms - r_record_start;
                        n_have_take   = 1'b1;
                        n_play_index  = '0;
                        n_play_start  = r_now_ms;
                        n_mode        = MODE_PLAY;
                    end else if ((r_mode == MODE_REC || r_mode == MODE_WEND)
                                 && !store_full) begin
                        wr_en         = 1'b1;
                        n_event_count = r_event_count + CNT_W'(1);
                    end
                end
                FUNC_TICK: begin
                    n_now_ms = tick_now;
                    if (play_tick) begin
                        if (tick_wrap) begin
                            n_play_index = '0;
                            n_play_start = tick_now;
                            n_loop_time  = '0;
                        end else begin
                            n_loop_time = tick_elapsed;
                        end
                    end
                end
                default: n_mode = r_mode;
            endcase
        end

        if (r_state == ST_EMIT && due && slot_free) begin
            n_out_valid             = 1'b1;
            n_out_beat.out_on       = rd_entry.on;
            n_out_beat.out_note     = rd_entry.note;
            n_out_beat.out_velocity = rd_entry.vel;
            n_out_beat.out_channel  = rd_entry.chan;
            n_play_index            = r_play_index + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_ACCEPT;
            r_mode         <= MODE_IDLE;
            r_have_take    <= 1'b0;
            r_now_ms       <= '0;
            r_record_start <= '0;
            r_play_start   <= '0;
            r_loop_length  <= '0;
            r_event_count  <= '0;
            r_play_index   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_mode         <= n_mode;
            r_have_take    <= n_have_take;
            r_now_ms       <= n_now_ms;
            r_record_start <= n_record_start;
            r_play_start   <= n_play_start;
            r_loop_length  <= n_loop_length;
            r_event_count  <= n_event_count;
            r_play_index   <= n_play_index;
            r_out_valid    <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_loop_time <= n_loop_time;
        r_out_beat  <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
